// ----- sv/tlc_pkg.sv -----
package tlc_pkg;

    localparam int TAG_W = 30;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_READ_HIT   = 3'd1,
        ST_READ_MISS  = 3'd2,
        ST_WRITE_HIT  = 3'd3,
        ST_WRITE_MISS = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        REG_L1_INDEX  = 3'd0,
        REG_L1_OFFSET = 3'd1,
        REG_L1_WAYS   = 3'd2,
        REG_L2_INDEX  = 3'd3,
        REG_L2_OFFSET = 3'd4,
        REG_L2_WAYS   = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CLEAR,
        PH_READ1,
        PH_EVAL1,
        PH_READ2,
        PH_EVAL2,
        PH_OUT
    } phase_t;

    // Request from the sequencer to one level store.
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } lvl_req_t;

    // Answer of one level store after a lookup.
    typedef struct packed {
        logic hit;
    } lvl_rsp_t;

endpackage

// ----- sv/tlc_level.sv -----
module tlc_level import tlc_pkg::*; #(
    parameter int SETS = 2048,
    parameter int WAYS = 4
) (
    input  logic                          aclk,
    input  logic [$clog2(SETS+1)-1:0]     set_idx,
    input  logic [TAG_W-1:0]              tag,
    input  logic [$clog2(WAYS+1)-1:0]     nways,
    input  logic                          fill_en,
    input  lvl_req_t                      req,
    output lvl_rsp_t                      rsp
);
    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int AW = 2;
    localparam int ROW_W = WAYS * (TAG_W + 1 + AW);

    // One row per set: tags, valid bits and ages of all ways.
    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] row_reg;
    logic [SW-1:0]    addr;
    logic [ROW_W-1:0] row_next;
    logic             hit;

    assign addr = set_idx[SW-1:0];

    always_ff @(posedge aclk) begin
        if (req.clr) begin
            mem[addr] <= '0;
        end else if (req.wr) begin
            mem[addr] <= row_next;
        end
        if (req.rd) begin
            row_reg <= mem[addr];
        end
    end

    always_comb begin
        logic [TAG_W-1:0] t   [WAYS];
        logic             v   [WAYS];
        logic [AW-1:0]    a   [WAYS];
        logic             act [WAYS];
        logic             found;
        logic             inv_found;
        logic [AW-1:0]    best;
        logic [AW-1:0]    old;
        int               hw;
        int               vw;
        int               tw;
        for (int i = 0; i < WAYS; i++) begin
            t[i] = row_reg[i*(TAG_W+1+AW) +: TAG_W];
            v[i] = row_reg[i*(TAG_W+1+AW)+TAG_W];
            a[i] = row_reg[i*(TAG_W+1+AW)+TAG_W+1 +: AW];
            act[i] = (i < int'(nways));
        end
        found = 1'b0;
        hw = 0;
        for (int i = WAYS-1; i >= 0; i--) begin
            if (act[i] && v[i] && t[i] == tag) begin
                found = 1'b1;
                hw = i;
            end
        end
        inv_found = 1'b0;
        vw = 0;
        for (int i = WAYS-1; i >= 0; i--) begin
            if (act[i] && !v[i]) begin
                inv_found = 1'b1;
                vw = i;
            end
        end
        best = '0;
        if (!inv_found) begin
            best = a[0];
            vw = 0;
            for (int i = 1; i < WAYS; i++) begin
                if (act[i] && a[i] > best) begin
                    best = a[i];
                    vw = i;
                end
            end
        end
        tw = found ? hw : vw;
        old = v[tw] ? a[tw] : AW'(int'(nways) - 1);
        row_next = row_reg;
        for (int i = 0; i < WAYS; i++) begin
            if (act[i] && i != tw && v[i] && a[i] < old) begin
                row_next[i*(TAG_W+1+AW)+TAG_W+1 +: AW] = a[i] + 1'b1;
            end
        end
        row_next[tw*(TAG_W+1+AW)+TAG_W+1 +: AW] = '0;
        if (!found && fill_en) begin
            row_next[tw*(TAG_W+1+AW) +: TAG_W] = tag;
            row_next[tw*(TAG_W+1+AW)+TAG_W] = 1'b1;
        end
        hit = found;
    end

    assign rsp.hit = hit;

endmodule

// ----- sv/two_level_cache_hit_miss_lru.sv -----
// Channel  Direction  Payload
// s_       in         tdata[0] func, tdata[32:1] addr
// m_       out        tdata[2:0] l1_status, tdata[5:3] l2_status
// cfg      in         cfg_wr_en, cfg_index, cfg_data
//
// An item that reads and hits in the first level ends there; every other item
// also looks up the second level. Each level is a read of one set row and then
// compare and LRU update, after which the row is written back unless a write missed.
// After reset a clearing pass writes every row of both stores, one row a
// cycle, up to the larger set count; no item is taken then.
// The result moves into an output register, so the next item can be looked up
// while it waits; a further result waits until that register has been taken.
module two_level_cache_hit_miss_lru import tlc_pkg::*; #(
    parameter int FIRST_SETS  = 2048,
    parameter int FIRST_WAYS  = 4,
    parameter int SECOND_SETS = 2048,
    parameter int SECOND_WAYS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func, addr
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // l1_status, l2_status
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    localparam int MAXS = (FIRST_SETS > SECOND_SETS) ? FIRST_SETS : SECOND_SETS;
    localparam int CW   = $clog2(MAXS + 1);
    localparam int S1W  = $clog2(FIRST_SETS + 1);
    localparam int S2W  = $clog2(SECOND_SETS + 1);
    localparam int N1W  = $clog2(FIRST_WAYS + 1);
    localparam int N2W  = $clog2(SECOND_WAYS + 1);

    // Largest index width that the set count supports, worked out at elaboration.
    function automatic logic [3:0] max_bits(input int sets);
        int b;
        b = 0;
        for (int i = 0; i < 15; i++) begin
            if ((1 << (b + 1)) <= sets) begin
                b = b + 1;
            end
        end
        return 4'(b);
    endfunction

    localparam logic [3:0] MAXB1 = max_bits(FIRST_SETS);
    localparam logic [3:0] MAXB2 = max_bits(SECOND_SETS);

    logic [3:0] l1_index_reg, l2_index_reg;
    logic [2:0] l1_offset_reg, l2_offset_reg, l1_ways_reg, l2_ways_reg;

    phase_t     phase_reg, phase_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic       func_reg;
    logic [31:0] addr_reg;
    status_t    s1_reg, s1_next, s2_reg, s2_next;
    logic       l1_hit_reg, l1_hit_next;
    logic       m_valid_reg, m_valid_next;
    logic [5:0] m_data_reg, m_data_next;

    lvl_req_t   req1, req2;
    lvl_rsp_t   rsp1, rsp2;
    logic       fill1, fill2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_index_reg  <= 4'd11;
            l1_offset_reg <= 3'd3;
            l1_ways_reg   <= 3'd1;
            l2_index_reg  <= 4'd9;
            l2_offset_reg <= 3'd4;
            l2_ways_reg   <= 3'd4;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_L1_INDEX:  l1_index_reg  <= cfg_data;
                REG_L1_OFFSET: l1_offset_reg <= cfg_data[2:0];
                REG_L1_WAYS:   l1_ways_reg   <= cfg_data[2:0];
                REG_L2_INDEX:  l2_index_reg  <= cfg_data;
                REG_L2_OFFSET: l2_offset_reg <= cfg_data[2:0];
                REG_L2_WAYS:   l2_ways_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Address split per level, with the saturations of the register fields.
    logic [2:0]  ob1, ob2;
    logic [3:0]  ib1, ib2;
    logic [31:0] set1_w, set2_w, tag1_w, tag2_w;
    logic [N1W-1:0] nw1;
    logic [N2W-1:0] nw2;
    logic [S1W-1:0] set1;
    logic [S2W-1:0] set2;

    always_comb begin
        ob1 = (l1_offset_reg < 3'd2) ? 3'd2 : l1_offset_reg;
        ob2 = (l2_offset_reg < 3'd2) ? 3'd2 : l2_offset_reg;
        ib1 = (l1_index_reg > MAXB1) ? MAXB1 : l1_index_reg;
        ib2 = (l2_index_reg > MAXB2) ? MAXB2 : l2_index_reg;
        set1_w = (addr_reg >> ob1) & ((32'd1 << ib1) - 32'd1);
        set2_w = (addr_reg >> ob2) & ((32'd1 << ib2) - 32'd1);
        tag1_w = addr_reg >> (5'(ob1) + 5'(ib1));
        tag2_w = addr_reg >> (5'(ob2) + 5'(ib2));
        if (l1_ways_reg == 3'd0) begin
            nw1 = N1W'(1);
        end else if (int'(l1_ways_reg) > FIRST_WAYS) begin
            nw1 = N1W'(FIRST_WAYS);
        end else begin
            nw1 = N1W'(l1_ways_reg);
        end
        if (l2_ways_reg == 3'd0) begin
            nw2 = N2W'(1);
        end else if (int'(l2_ways_reg) > SECOND_WAYS) begin
            nw2 = N2W'(SECOND_WAYS);
        end else begin
            nw2 = N2W'(l2_ways_reg);
        end
        set1 = (phase_reg == PH_CLEAR) ? S1W'(clr_reg) : S1W'(set1_w);
        set2 = (phase_reg == PH_CLEAR) ? S2W'(clr_reg) : S2W'(set2_w);
    end

    tlc_level #(.SETS(FIRST_SETS), .WAYS(FIRST_WAYS)) u_l1 (
        .aclk(aclk), .set_idx(set1), .tag(tag1_w[TAG_W-1:0]), .nways(nw1),
        .fill_en(fill1), .req(req1), .rsp(rsp1)
    );

    tlc_level #(.SETS(SECOND_SETS), .WAYS(SECOND_WAYS)) u_l2 (
        .aclk(aclk), .set_idx(set2), .tag(tag2_w[TAG_W-1:0]), .nways(nw2),
        .fill_en(fill2), .req(req2), .rsp(rsp2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        l1_hit_reg <= l1_hit_next;
        m_data_reg <= m_data_next;
        if (s_tvalid && s_tready) begin
            func_reg <= s_tdata[0];
            addr_reg <= s_tdata[32:1];
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        clr_next     = clr_reg;
        s1_next      = s1_reg;
        s2_next      = s2_reg;
        l1_hit_next  = l1_hit_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        req1  = '0;
        req2  = '0;
        fill1 = 1'b0;
        fill2 = 1'b0;
        s_tready = 1'b0;
        // The receiver taking the held result frees the output register.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (phase_reg)
            PH_CLEAR: begin
                req1.clr = (int'(clr_reg) < FIRST_SETS);
                req2.clr = (int'(clr_reg) < SECOND_SETS);
                clr_next = clr_reg + 1'b1;
                if (int'(clr_reg) == MAXS - 1) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    phase_next = PH_READ1;
                end
            end
            PH_READ1: begin
                req1.rd = 1'b1;
                phase_next = PH_EVAL1;
            end
            PH_EVAL1: begin
                // Reads fill on a miss; writes only refresh LRU on a hit.
                fill1 = !func_reg;
                req1.wr = rsp1.hit || !func_reg;
                l1_hit_next = rsp1.hit;
                if (func_reg) begin
                    s1_next = rsp1.hit ? ST_WRITE_HIT : ST_WRITE_MISS;
                end else begin
                    s1_next = rsp1.hit ? ST_READ_HIT : ST_READ_MISS;
                end
                s2_next = ST_NONE;
                phase_next = (!func_reg && rsp1.hit) ? PH_OUT : PH_READ2;
            end
            PH_READ2: begin
                req2.rd = 1'b1;
                phase_next = PH_EVAL2;
            end
            PH_EVAL2: begin
                fill2 = !func_reg;
                req2.wr = rsp2.hit || !func_reg;
                if (func_reg) begin
                    s2_next = rsp2.hit ? ST_WRITE_HIT : ST_WRITE_MISS;
                end else begin
                    s2_next = rsp2.hit ? ST_READ_HIT : ST_READ_MISS;
                end
                phase_next = PH_OUT;
            end
            PH_OUT: begin
                // The status pair moves on once the output register is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {s2_reg, s1_reg};
                    phase_next   = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

`ifndef SYNTHESIS
    // A read that hit the first level never reports a second level access.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == ST_READ_HIT) |-> (m_tdata[5:3] == ST_NONE))
        else $error("second level reported after first level read hit");

    // A result held back by the receiver stays offered and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("held result changed or dropped");

    // Every accepted item reaches the first level lookup next.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (phase_reg == PH_READ1))
        else $error("accepted item not looked up");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import tlc_pkg::*;

    localparam int L1_SETS = 2048;
    localparam int L1_CAP  = 4;
    localparam int L2_SETS = 2048;
    localparam int L2_CAP  = 4;

    // One access as the sender offers it.
    typedef struct packed {
        logic        is_write;
        logic [31:0] addr;
    } access_t;

    // Both status fields of one result item.
    typedef struct packed {
        status_t l1;
        status_t l2;
    } outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // func, addr
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // l1_status, l2_status
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [3:0]  cfg_data;

    two_level_cache_hit_miss_lru i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The testbench's own copy of both levels, indexed by set * capacity + way.
    logic [29:0] l1_tag   [L1_SETS*L1_CAP];
    logic        l1_valid [L1_SETS*L1_CAP];
    logic [1:0]  l1_rank  [L1_SETS*L1_CAP];
    logic [29:0] l2_tag   [L2_SETS*L2_CAP];
    logic        l2_valid [L2_SETS*L2_CAP];
    logic [1:0]  l2_rank  [L2_SETS*L2_CAP];
    logic [3:0]  geom     [6];

    access_t  pending_accesses[$];
    outcome_t expected_outcomes[$];

    int  error_count = 0;
    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    bit  hold_receiver = 0;

    // The handshake seen at the last rising edge; the driver uses it to move on.
    logic s_tready_seen = 0;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Splits an address for one level, with the same saturation the block applies to
    // out-of-range geometry settings.
    function automatic void split_address(input logic [31:0] addr, input logic [3:0] ib_cfg,
                                          input logic [3:0] ob_cfg, input logic [3:0] ways_cfg,
                                          input int sets, input int cap,
                                          output int base, output logic [29:0] tag,
                                          output int nways);
        int maxb;
        int ib;
        int ob;
        logic [31:0] set_no;
        maxb = 0;
        while (maxb < 15 && (1 << (maxb + 1)) <= sets) maxb++;
        ob = (ob_cfg < 2) ? 2 : ob_cfg;
        ib = (ib_cfg > maxb) ? maxb : ib_cfg;
        set_no = (addr >> ob) & ((32'd1 << ib) - 1);
        tag = 30'((addr >> (ob + ib)));
        nways = (ways_cfg == 0) ? 1 : ((ways_cfg > cap) ? cap : ways_cfg);
        base = set_no * cap;
    endfunction

    // Lookup, LRU touch and fill for the first level; the second level mirrors them.
    function automatic int l1_find(int base, int nw, logic [29:0] tag);
        for (int w = 0; w < nw; w++)
            if (l1_valid[base+w] && l1_tag[base+w] == tag) return w;
        return -1;
    endfunction

    function automatic int l2_find(int base, int nw, logic [29:0] tag);
        for (int w = 0; w < nw; w++)
            if (l2_valid[base+w] && l2_tag[base+w] == tag) return w;
        return -1;
    endfunction

    function automatic void l1_touch(int base, int nw, int w);
        int old;
        old = l1_valid[base+w] ? l1_rank[base+w] : nw - 1;
        for (int j = 0; j < nw; j++)
            if (j != w && l1_valid[base+j] && l1_rank[base+j] < old)
                l1_rank[base+j] = l1_rank[base+j] + 1;
        l1_rank[base+w] = 0;
    endfunction

    function automatic void l2_touch(int base, int nw, int w);
        int old;
        old = l2_valid[base+w] ? l2_rank[base+w] : nw - 1;
        for (int j = 0; j < nw; j++)
            if (j != w && l2_valid[base+j] && l2_rank[base+j] < old)
                l2_rank[base+j] = l2_rank[base+j] + 1;
        l2_rank[base+w] = 0;
    endfunction

    // Victim choice: lowest invalid way, else the oldest, the lowest way winning a tie.
    function automatic void l1_fill(int base, int nw, logic [29:0] tag);
        int victim;
        victim = -1;
        for (int w = 0; w < nw && victim < 0; w++)
            if (!l1_valid[base+w]) victim = w;
        if (victim < 0) begin
            victim = 0;
            for (int w = 1; w < nw; w++)
                if (l1_rank[base+w] > l1_rank[base+victim]) victim = w;
        end
        l1_touch(base, nw, victim);
        l1_tag[base+victim] = tag;
        l1_valid[base+victim] = 1;
    endfunction

    function automatic void l2_fill(int base, int nw, logic [29:0] tag);
        int victim;
        victim = -1;
        for (int w = 0; w < nw && victim < 0; w++)
            if (!l2_valid[base+w]) victim = w;
        if (victim < 0) begin
            victim = 0;
            for (int w = 1; w < nw; w++)
                if (l2_rank[base+w] > l2_rank[base+victim]) victim = w;
        end
        l2_touch(base, nw, victim);
        l2_tag[base+victim] = tag;
        l2_valid[base+victim] = 1;
    endfunction

    // Works out the status pair of one accepted access and updates both levels.
    function automatic outcome_t predict_access(access_t acc);
        int b1, b2, n1, n2, w;
        logic [29:0] t1, t2;
        outcome_t res;
        split_address(acc.addr, geom[REG_L1_INDEX], geom[REG_L1_OFFSET], geom[REG_L1_WAYS],
                      L1_SETS, L1_CAP, b1, t1, n1);
        split_address(acc.addr, geom[REG_L2_INDEX], geom[REG_L2_OFFSET], geom[REG_L2_WAYS],
                      L2_SETS, L2_CAP, b2, t2, n2);
        res.l2 = ST_NONE;
        w = l1_find(b1, n1, t1);
        if (!acc.is_write) begin
            if (w >= 0) begin
                res.l1 = ST_READ_HIT;
                l1_touch(b1, n1, w);
            end else begin
                res.l1 = ST_READ_MISS;
                w = l2_find(b2, n2, t2);
                if (w >= 0) begin
                    res.l2 = ST_READ_HIT;
                    l2_touch(b2, n2, w);
                end else begin
                    res.l2 = ST_READ_MISS;
                    l2_fill(b2, n2, t2);
                end
                l1_fill(b1, n1, t1);
            end
        end else begin
            // Write-through with no allocation: only ranks change, and only on a hit.
            if (w >= 0) begin
                res.l1 = ST_WRITE_HIT;
                l1_touch(b1, n1, w);
            end else begin
                res.l1 = ST_WRITE_MISS;
            end
            w = l2_find(b2, n2, t2);
            if (w >= 0) begin
                res.l2 = ST_WRITE_HIT;
                l2_touch(b2, n2, w);
            end else begin
                res.l2 = ST_WRITE_MISS;
            end
        end
        return res;
    endfunction

    // Driver: a new item is presented at the falling edge once the previous one has gone.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_seen) begin
                if (pending_accesses.size() > 0 &&
                    $urandom_range(99, 0) >= sender_idle_pct) begin
                    s_tdata  <= {7'd0, pending_accesses[0].addr, pending_accesses[0].is_write};
                    s_tvalid <= 1'b1;
                    void'(pending_accesses.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !hold_receiver && ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    // Monitor: predicts on input acceptance and checks each result against the oldest
    // expectation.
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        access_t  acc;
        s_tready_seen <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                acc.is_write = s_tdata[0];
                acc.addr     = s_tdata[32:1];
                expected_outcomes.push_back(predict_access(acc));
            end
            if (m_tvalid && m_tready) begin
                got = outcome_t'({m_tdata[2:0], m_tdata[5:3]});
                if (expected_outcomes.size() == 0) begin
                    $error("result item with no expectation: l1_status %0d l2_status %0d",
                           got.l1, got.l2);
                    error_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got.l1 !== want.l1) begin
                        $error("l1_status: expected %0d, actual %0d", want.l1, got.l1);
                        error_count++;
                    end
                    if (got.l2 !== want.l2) begin
                        $error("l2_status: expected %0d, actual %0d", want.l2, got.l2);
                        error_count++;
                    end
                end
            end
        end
    end

    // Waits until every queued item has been accepted and answered.
    task automatic drain();
        while (pending_accesses.size() > 0 || s_tvalid || expected_outcomes.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [3:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        // Only the register's own width is kept.
        geom[idx] = (idx == REG_L1_INDEX || idx == REG_L2_INDEX) ? value : {1'b0, value[2:0]};
    endtask

    task automatic set_geometry(logic [3:0] i1, logic [3:0] o1, logic [3:0] w1,
                                logic [3:0] i2, logic [3:0] o2, logic [3:0] w2);
        write_reg(REG_L1_INDEX, i1);
        write_reg(REG_L1_OFFSET, o1);
        write_reg(REG_L1_WAYS, w1);
        write_reg(REG_L2_INDEX, i2);
        write_reg(REG_L2_OFFSET, o2);
        write_reg(REG_L2_WAYS, w2);
    endtask

    // Addresses drawn from a small pool of lines so that hits, conflicts and evictions
    // happen often; a share are fully random.
    function automatic access_t random_access(logic [31:0] pool_base);
        access_t a;
        a.is_write = ($urandom_range(3, 0) == 0);
        if ($urandom_range(9, 0) == 0)
            a.addr = $urandom;
        else
            a.addr = pool_base ^ ($urandom_range(15, 0) << $urandom_range(12, 2))
                     ^ $urandom_range(3, 0);
        return a;
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        logic [31:0] pool_base;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        pool_base = $urandom;
        for (int k = 0; k < count; k++) pending_accesses.push_back(random_access(pool_base));
        drain();
    endtask

    initial begin
        int hold_cycles;
        aresetn   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        m_tready  = 0;
        cfg_wr_en = 0;
        cfg_index = REG_L1_INDEX;
        cfg_data  = '0;
        for (int i = 0; i < L1_SETS*L1_CAP; i++) begin
            l1_valid[i] = 0; l1_rank[i] = 0; l1_tag[i] = '0;
        end
        for (int i = 0; i < L2_SETS*L2_CAP; i++) begin
            l2_valid[i] = 0; l2_rank[i] = 0; l2_tag[i] = '0;
        end
        geom[REG_L1_INDEX] = 11; geom[REG_L1_OFFSET] = 3; geom[REG_L1_WAYS] = 1;
        geom[REG_L2_INDEX] = 9;  geom[REG_L2_OFFSET] = 4; geom[REG_L2_WAYS] = 4;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed part at reset geometry: extremes of the address, read miss then read
        // hit, write hit and write miss on both levels, and an L1 conflict served by L2.
        pending_accesses.push_back('{1'b0, 32'h0000_0000});
        pending_accesses.push_back('{1'b0, 32'h0000_0000});
        pending_accesses.push_back('{1'b1, 32'h0000_0004});
        pending_accesses.push_back('{1'b1, 32'hFFFF_FFFF});
        pending_accesses.push_back('{1'b0, 32'hFFFF_FFFF});
        pending_accesses.push_back('{1'b1, 32'hFFFF_FFF8});
        pending_accesses.push_back('{1'b0, 32'h0000_4000});
        pending_accesses.push_back('{1'b0, 32'h0000_0000});
        pending_accesses.push_back('{1'b0, 32'hAAAA_AAAA});
        pending_accesses.push_back('{1'b1, 32'h5555_5555});
        drain();

        // Zero ways, offsets below two and over-wide index are all saturated.
        set_geometry(4'd15, 4'd0, 4'd0, 4'd0, 4'd1, 4'd7);
        for (int k = 0; k < 6; k++) pending_accesses.push_back('{k[0], 32'(k) << 16});
        pending_accesses.push_back('{1'b0, 32'h0000_0000});
        pending_accesses.push_back('{1'b0, 32'hFFFF_FFFF});
        drain();

        // Small caches with full associativity: evictions are frequent.
        set_geometry(4'd1, 4'd2, 4'd4, 4'd2, 4'd2, 4'd4);
        random_phase(250, 0, 0);

        // Ways lowered afterwards: the upper ways keep their lines but go unused.
        set_geometry(4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3);
        random_phase(250, 45, 0);

        set_geometry(4'd11, 4'd7, 4'd3, 4'd11, 4'd7, 4'd1);
        random_phase(250, 0, 45);

        set_geometry(4'd0, 4'd4, 4'd4, 4'd3, 4'd5, 4'd2);
        random_phase(250, 34, 34);

        // Long receiver hold-off while the sender keeps offering, then the receiver is
        // released and the bench waits until the block has answered everything.
        set_geometry(4'd3, 4'd3, 4'd4, 4'd6, 4'd4, 4'd4);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_receiver = 1;
        begin
            logic [31:0] pool_base;
            pool_base = $urandom;
            for (int k = 0; k < 250; k++) pending_accesses.push_back(random_access(pool_base));
        end
        hold_cycles = 0;
        while (hold_cycles < 200) begin
            @(posedge aclk);
            hold_cycles++;
        end
        hold_receiver = 0;
        drain();

        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_outcomes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // The clearing pass after reset and every stall are well inside this bound.
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
